FILE: src/bal_pkg.sv
`timescale 1ns / 1ps

package bal_pkg;

  localparam int CAPACITY = 128;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;
  localparam int KEY_W    = 32;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 2;
  localparam int ECNT_W   = 8;
  localparam int POSIN_W  = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_SEARCH = 3'd2,
    KIND_INSERT = 3'd3,
    KIND_REMOVE = 3'd4,
    KIND_READ   = 3'd5
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_NOKEY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMPACT,
    S_SCAN,
    S_SHIFT,
    S_RDWAIT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [DATA_W-1:0]       data;
  } entry_t;

endpackage

FILE: src/bounded_array_list.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake                | Payload
// input   | in        | in_valid_i / in_ready_o  | kind_i, item_key_i, item_data_i, position_i
// output  | out       | out_valid_o / out_ready_i| status_o, out_key_o, out_data_o,
//         |           |                          | entry_count_o, list_empty_o, list_full_o
//
// One item at a time. Append and rejected items go from idle to finish; read
// passes a read-wait state first. Search, delete by key, insert and remove walk
// the entry memory, one read and at most one write per cycle (search only reads).
// Reset clears state, entry count and output valid; entry memory is not cleared.
// A new item is taken while the previous result waits on out_ready_i; a result
// that finds the output register full holds until it drains.

module bounded_array_list (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bal_pkg::KIND_W-1:0]          kind_i,
  input  logic signed [bal_pkg::KEY_W-1:0]    item_key_i,
  input  logic [bal_pkg::DATA_W-1:0]          item_data_i,
  input  logic [bal_pkg::POSIN_W-1:0]         position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bal_pkg::STAT_W-1:0]          status_o,
  output logic signed [bal_pkg::KEY_W-1:0]    out_key_o,
  output logic [bal_pkg::DATA_W-1:0]          out_data_o,
  output logic [bal_pkg::ECNT_W-1:0]          entry_count_o,
  output logic                                list_empty_o,
  output logic                                list_full_o
);
  import bal_pkg::*;

  entry_t mem_q [CAPACITY];
  entry_t rd_q;

  state_e state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  rptr_q, rptr_d;
  logic [CNT_W-1:0]  wptr_q, wptr_d;
  logic [IDX_W-1:0]  pidx_q, pidx_d;
  logic [IDX_W-1:0]  posidx_q, posidx_d;
  logic              pend_q, pend_d;
  logic              hit_q, hit_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [DATA_W-1:0] data_q, data_d;
  status_e           status_q, status_d;
  logic signed [KEY_W-1:0] okey_q, okey_d;
  logic [DATA_W-1:0] odata_q, odata_d;

  logic              out_valid_q, out_valid_d;
  status_e           res_status_q, res_status_d;
  logic signed [KEY_W-1:0] res_key_q, res_key_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic [ECNT_W-1:0] res_cnt_q, res_cnt_d;
  logic              res_empty_q, res_empty_d;
  logic              res_full_q, res_full_d;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;

  logic              full_w;
  logic [POS_W-1:0]  pos_ext;
  logic [POS_W-1:0]  cnt_ext;
  logic [IDX_W-1:0]  pos_idx_in;
  logic              drop;

  assign full_w     = (count_q == CNT_W'(CAPACITY));
  assign pos_ext    = POS_W'(position_i);
  assign cnt_ext    = POS_W'(count_q);
  assign pos_idx_in = IDX_W'(pos_ext - POS_W'(1));
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rptr_d       = rptr_q;
    wptr_d       = wptr_q;
    pidx_d       = pidx_q;
    posidx_d     = posidx_q;
    pend_d       = 1'b0;
    hit_d        = hit_q;
    kind_d       = kind_q;
    key_d        = key_q;
    data_d       = data_q;
    status_d     = status_q;
    okey_d       = okey_q;
    odata_d      = odata_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_data_d   = res_data_q;
    res_cnt_d    = res_cnt_q;
    res_empty_d  = res_empty_q;
    res_full_d   = res_full_q;
    mem_we       = 1'b0;
    mem_waddr    = IDX_W'(wptr_q);
    mem_wdata    = rd_q;
    mem_raddr    = pos_idx_in;
    drop         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d   = kind_i;
          key_d    = item_key_i;
          data_d   = item_data_i;
          posidx_d = pos_idx_in;
          okey_d   = '0;
          odata_d  = '0;
          status_d = ST_OK;
          hit_d    = 1'b0;
          state_d  = S_FINISH;
          case (kind_i)
            KIND_APPEND: begin
              if (full_w) begin
                status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(count_q);
                mem_wdata = '{key: item_key_i, data: item_data_i};
                count_d   = count_q + CNT_W'(1);
              end
            end
            KIND_DELETE: begin
              rptr_d  = '0;
              wptr_d  = '0;
              state_d = S_COMPACT;
            end
            KIND_SEARCH: begin
              rptr_d  = '0;
              state_d = S_SCAN;
            end
            KIND_INSERT: begin
              if (full_w) begin
                status_d = ST_FULL;
              end else if (pos_ext == '0 || pos_ext > cnt_ext + POS_W'(1)) begin
                status_d = ST_BADPOS;
              end else begin
                rptr_d  = count_q;
                state_d = S_SHIFT;
              end
            end
            KIND_REMOVE: begin
              if (pos_ext == '0 || pos_ext > cnt_ext) begin
                status_d = ST_BADPOS;
              end else begin
                rptr_d  = CNT_W'(pos_idx_in);
                wptr_d  = CNT_W'(pos_idx_in);
                state_d = S_COMPACT;
              end
            end
            KIND_READ: begin
              if (pos_ext == '0 || pos_ext > cnt_ext) begin
                status_d = ST_BADPOS;
              end else begin
                state_d = S_RDWAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_COMPACT: begin
        if (pend_q) begin
          drop = ((kind_q == KIND_DELETE) && (rd_q.key == key_q)) ||
                 ((kind_q == KIND_REMOVE) && (pidx_q == posidx_q));
          if (drop) begin
            hit_d = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(wptr_q);
            mem_wdata = rd_q;
            wptr_d    = wptr_q + CNT_W'(1);
          end
        end
        mem_raddr = IDX_W'(rptr_q);
        if (rptr_q < count_q) begin
          pend_d = 1'b1;
          pidx_d = IDX_W'(rptr_q);
          rptr_d = rptr_q + CNT_W'(1);
        end else if (!pend_q) begin
          count_d  = (count_q == '0) ? '0 : wptr_q;
          status_d = ((kind_q == KIND_DELETE) && !hit_q) ? ST_NOKEY : ST_OK;
          state_d  = S_FINISH;
        end
      end

      S_SCAN: begin
        mem_raddr = IDX_W'(rptr_q);
        if (pend_q && (rd_q.key == key_q)) begin
          okey_d   = rd_q.key;
          odata_d  = rd_q.data;
          status_d = ST_OK;
          state_d  = S_FINISH;
        end else if (rptr_q < count_q) begin
          pend_d = 1'b1;
          rptr_d = rptr_q + CNT_W'(1);
        end else if (!pend_q) begin
          status_d = ST_NOKEY;
          state_d  = S_FINISH;
        end
      end

      S_SHIFT: begin
        mem_raddr = IDX_W'(rptr_q - CNT_W'(1));
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_q + IDX_W'(1);
          mem_wdata = rd_q;
        end
        if (rptr_q > CNT_W'(posidx_q)) begin
          pend_d = 1'b1;
          pidx_d = IDX_W'(rptr_q - CNT_W'(1));
          rptr_d = rptr_q - CNT_W'(1);
        end else if (!pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = posidx_q;
          mem_wdata = '{key: key_q, data: data_q};
          count_d   = count_q + CNT_W'(1);
          state_d   = S_FINISH;
        end
      end

      S_RDWAIT: begin
        okey_d  = rd_q.key;
        odata_d = rd_q.data;
        state_d = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          res_status_d = status_q;
          res_key_d    = okey_q;
          res_data_d   = odata_q;
          res_cnt_d    = ECNT_W'(count_q);
          res_empty_d  = (count_q == '0);
          res_full_d   = full_w;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rptr_q       <= rptr_d;
    wptr_q       <= wptr_d;
    pidx_q       <= pidx_d;
    posidx_q     <= posidx_d;
    kind_q       <= kind_d;
    key_q        <= key_d;
    data_q       <= data_d;
    status_q     <= status_d;
    okey_q       <= okey_d;
    odata_q      <= odata_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_data_q   <= res_data_d;
    res_cnt_q    <= res_cnt_d;
    res_empty_q  <= res_empty_d;
    res_full_q   <= res_full_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_status_q;
  assign out_key_o     = res_key_q;
  assign out_data_o    = res_data_q;
  assign entry_count_o = res_cnt_q;
  assign list_empty_o  = res_empty_q;
  assign list_full_o   = res_full_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result raised outside finish");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == S_IDLE) |-> (in_valid_i && kind_i == KIND_APPEND))
    else $error("memory write in idle without append");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMPACT && pend_q) |-> (wptr_q <= CNT_W'(pidx_q)))
    else $error("compaction write pointer ahead of read");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bal_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam int SETTLE_CYCLES = CAPACITY + 8;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [KEY_W-1:0] key;
    logic [DATA_W-1:0]       data;
    logic [ECNT_W-1:0]       count;
    logic                    empty;
    logic                    full;
  } outcome_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [KIND_W-1:0]         kind_i = '0;
  logic signed [KEY_W-1:0]   item_key_i = '0;
  logic [DATA_W-1:0]         item_data_i = '0;
  logic [POSIN_W-1:0]        position_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [STAT_W-1:0]         status_o;
  logic signed [KEY_W-1:0]   out_key_o;
  logic [DATA_W-1:0]         out_data_o;
  logic [ECNT_W-1:0]         entry_count_o;
  logic                      list_empty_o;
  logic                      list_full_o;

  logic signed [KEY_W-1:0]   list_keys [CAPACITY];
  logic [DATA_W-1:0]         list_data [CAPACITY];
  int                        list_count = 0;
  logic signed [KEY_W-1:0]   key_pool [8];
  outcome_t                  expected_outcomes [$];
  int                        error_count = 0;
  bit                        no_idle = 1'b0;

  bounded_array_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .item_key_i    (item_key_i),
    .item_data_i   (item_data_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_data_o    (out_data_o),
    .entry_count_o (entry_count_o),
    .list_empty_o  (list_empty_o),
    .list_full_o   (list_full_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic outcome_t predict_outcome(input logic [KIND_W-1:0] kind,
                                               input logic signed [KEY_W-1:0] key,
                                               input logic [DATA_W-1:0] data,
                                               input logic [POSIN_W-1:0] pos);
    outcome_t o;
    int p;
    int kept;
    bit hit;
    o = '0;
    o.status = ST_OK;
    p = int'(pos);
    case (kind)
      KIND_APPEND: begin
        if (list_count >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          list_keys[list_count] = key;
          list_data[list_count] = data;
          list_count++;
        end
      end
      KIND_DELETE: begin
        kept = 0;
        hit = 1'b0;
        for (int i = 0; i < list_count; i++) begin
          if (list_keys[i] == key) begin
            hit = 1'b1;
          end else begin
            list_keys[kept] = list_keys[i];
            list_data[kept] = list_data[i];
            kept++;
          end
        end
        list_count = kept;
        if (!hit) o.status = ST_NOKEY;
      end
      KIND_SEARCH: begin
        o.status = ST_NOKEY;
        for (int i = 0; i < list_count; i++) begin
          if (o.status == ST_NOKEY && list_keys[i] == key) begin
            o.status = ST_OK;
            o.key = list_keys[i];
            o.data = list_data[i];
          end
        end
      end
      KIND_INSERT: begin
        if (list_count >= CAPACITY) begin
          o.status = ST_FULL;
        end else if (p < 1 || p > list_count + 1) begin
          o.status = ST_BADPOS;
        end else begin
          for (int i = list_count; i >= p; i--) begin
            list_keys[i] = list_keys[i-1];
            list_data[i] = list_data[i-1];
          end
          list_keys[p-1] = key;
          list_data[p-1] = data;
          list_count++;
        end
      end
      KIND_REMOVE: begin
        if (p < 1 || p > list_count) begin
          o.status = ST_BADPOS;
        end else begin
          for (int i = p - 1; i + 1 < list_count; i++) begin
            list_keys[i] = list_keys[i+1];
            list_data[i] = list_data[i+1];
          end
          list_count--;
        end
      end
      KIND_READ: begin
        if (p < 1 || p > list_count) begin
          o.status = ST_BADPOS;
        end else begin
          o.key = list_keys[p-1];
          o.data = list_data[p-1];
        end
      end
      default: ;
    endcase
    o.count = list_count[ECNT_W-1:0];
    o.empty = (list_count == 0);
    o.full = (list_count >= CAPACITY);
    return o;
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic signed [KEY_W-1:0] key,
                           input logic [DATA_W-1:0] data, input logic [POSIN_W-1:0] pos);
    if (!no_idle && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 30);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    item_key_i <= key;
    item_data_i <= data;
    position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    expected_outcomes.push_back(predict_outcome(kind, key, data, pos));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with nothing expected: status %0d count %0d", status_o, entry_count_o);
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (out_key_o !== want.key) begin
          $error("out_key: expected %0d, got %0d", want.key, out_key_o);
          error_count++;
        end
        if (out_data_o !== want.data) begin
          $error("out_data: expected %h, got %h", want.data, out_data_o);
          error_count++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
          error_count++;
        end
        if (list_empty_o !== want.empty) begin
          $error("list_empty: expected %0b, got %0b", want.empty, list_empty_o);
          error_count++;
        end
        if (list_full_o !== want.full) begin
          $error("list_full: expected %0b, got %0b", want.full, list_full_o);
          error_count++;
        end
      end
    end
    out_ready_i <= no_idle || ($urandom_range(99) >= 18);
  end

  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 70) return key_pool[$urandom_range(7)];
    if (r < 75) return KEY_MIN;
    if (r < 80) return KEY_MAX;
    return $urandom;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(input bit grow);
    int r;
    r = $urandom_range(99);
    if (grow) begin
      if (r < 35) return KIND_APPEND;
      if (r < 60) return KIND_INSERT;
      if (r < 65) return KIND_DELETE;
      if (r < 75) return KIND_SEARCH;
      if (r < 83) return KIND_REMOVE;
      if (r < 95) return KIND_READ;
    end else begin
      if (r < 8) return KIND_APPEND;
      if (r < 15) return KIND_INSERT;
      if (r < 35) return KIND_DELETE;
      if (r < 45) return KIND_SEARCH;
      if (r < 80) return KIND_REMOVE;
      if (r < 95) return KIND_READ;
    end
    return (r < 98) ? KIND_SPARE_A : KIND_SPARE_B;
  endfunction

  function automatic logic [POSIN_W-1:0] pick_position(input logic [KIND_W-1:0] kind);
    int r;
    int lim;
    r = $urandom_range(99);
    lim = (kind == KIND_INSERT) ? list_count + 1 : ((list_count > 0) ? list_count : 1);
    if (r < 80) return POSIN_W'($urandom_range(lim, 1));
    if (r < 88) return '0;
    return POSIN_W'($urandom_range(255));
  endfunction

  task automatic check_empty_list();
    send_item(KIND_SEARCH, KEY_MIN, 32'h0, 8'd0);
    send_item(KIND_DELETE, KEY_MAX, 32'h0, 8'd0);
    send_item(KIND_READ, 32'sd0, 32'h0, 8'd0);
    send_item(KIND_READ, 32'sd0, 32'h0, 8'd1);
    send_item(KIND_REMOVE, 32'sd0, 32'h0, 8'd1);
    send_item(KIND_INSERT, 32'sd5, 32'h1234_5678, 8'd2);
    send_item(KIND_INSERT, 32'sd5, 32'h1234_5678, 8'd0);
    send_item(KIND_SPARE_A, KEY_MAX, 32'hFFFF_FFFF, 8'd255);
    send_item(KIND_SPARE_B, KEY_MIN, 32'hFFFF_FFFF, 8'd255);
  endtask

  task automatic check_list_edges();
    send_item(KIND_APPEND, KEY_MIN, 32'h0000_0000, 8'd0);
    send_item(KIND_APPEND, KEY_MAX, 32'hFFFF_FFFF, 8'd255);
    send_item(KIND_INSERT, 32'sd0, 32'hA5A5_A5A5, 8'd1);
    send_item(KIND_INSERT, -32'sd1, 32'h5A5A_5A5A, 8'd4);
    send_item(KIND_INSERT, 32'sd9, 32'h0, 8'd6);
    send_item(KIND_READ, 32'sd0, 32'h0, 8'd1);
    send_item(KIND_READ, 32'sd0, 32'h0, 8'd4);
    send_item(KIND_READ, 32'sd0, 32'h0, 8'd5);
    send_item(KIND_READ, 32'sd0, 32'h0, 8'd255);
    send_item(KIND_SEARCH, KEY_MIN, 32'h0, 8'd0);
    send_item(KIND_SEARCH, KEY_MAX, 32'h0, 8'd0);
    send_item(KIND_REMOVE, 32'sd0, 32'h0, 8'd2);
    send_item(KIND_REMOVE, 32'sd0, 32'h0, 8'd0);
    send_item(KIND_REMOVE, 32'sd0, 32'h0, 8'd255);
    send_item(KIND_APPEND, 32'sd7, 32'h1111_1111, 8'd0);
    send_item(KIND_INSERT, 32'sd7, 32'h2222_2222, 8'd1);
    send_item(KIND_SEARCH, 32'sd7, 32'h0, 8'd0);
    send_item(KIND_DELETE, 32'sd7, 32'h0, 8'd0);
    send_item(KIND_SEARCH, 32'sd7, 32'h0, 8'd0);
  endtask

  task automatic check_full_list();
    while (list_count < CAPACITY) begin
      send_item(KIND_APPEND, pick_key(), $urandom, POSIN_W'($urandom));
    end
    send_item(KIND_APPEND, KEY_MAX, 32'hFFFF_FFFF, 8'd0);
    send_item(KIND_INSERT, 32'sd1, 32'h0, 8'd1);
    send_item(KIND_INSERT, 32'sd1, 32'h0, 8'd200);
    send_item(KIND_READ, 32'sd0, 32'h0, POSIN_W'(CAPACITY));
    send_item(KIND_READ, 32'sd0, 32'h0, POSIN_W'(CAPACITY + 1));
    send_item(KIND_SEARCH, key_pool[3], 32'h0, 8'd0);
    send_item(KIND_REMOVE, 32'sd0, 32'h0, POSIN_W'(CAPACITY));
    send_item(KIND_INSERT, KEY_MIN, $urandom, POSIN_W'(CAPACITY));
    send_item(KIND_REMOVE, 32'sd0, 32'h0, 8'd1);
    send_item(KIND_INSERT, KEY_MAX, $urandom, POSIN_W'(CAPACITY));
    send_item(KIND_DELETE, key_pool[0], 32'h0, 8'd0);
    send_item(KIND_DELETE, key_pool[1], 32'h0, 8'd0);
  endtask

  task automatic check_random_mix(input int n_items, input bit grow);
    logic [KIND_W-1:0] kind;
    repeat (n_items) begin
      kind = pick_kind(grow);
      send_item(kind, pick_key(), $urandom, pick_position(kind));
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_empty_list();
    check_list_edges();
    check_full_list();
    check_random_mix(150, 1'b0);
    check_random_mix(150, 1'b1);
    no_idle = 1'b1;
    check_random_mix(200, 1'b1);
    no_idle = 1'b0;
    wait_for_results();
    check_random_mix(200, 1'b0);
    check_random_mix(150, 1'b1);
    check_random_mix(80, 1'b0);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
